### rtl/core/dclms_pkg.sv
`timescale 1ns / 1ps

package dclms_pkg;

  // opcode field values
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // bit positions inside the two-bit color field
  localparam int COLOR_RED_BIT   = 0;
  localparam int COLOR_GREEN_BIT = 1;

  // fixed field widths
  localparam int ROW_ADDR_W = 4;
  localparam int PIXEL_X_W  = 7;
  localparam int PIXEL_Y_W  = 6;

  typedef logic [1:0] color_t;

endpackage

### rtl/core/dual_color_led_matrix_scan_top.sv
`timescale 1ns / 1ps

// channel | handshake          | payload
// --------+--------------------+-------------------------------------------------
// in      | in_valid, in_stall | opcode, pixel_x, pixel_y, pixel_color
// out     | out_valid,out_stall| red_upper_n, red_lower_n, green_upper_n,
//         |                    | green_lower_n, row_address, latch_last
//
// a draw inside the panel reads its row, then writes it back; one outside is dropped
// a refresh tick runs a two-port row read, shift register load, then one column per
// cycle out of the shift registers while out_stall is low
// reset clears the state machine, scan row, column counter and per-row valid bits;
// an unwritten frame store row reads as all unlit, so no clearing pass is needed
// out_stall holds the current column in place; in_stall is high whenever busy

module dual_color_led_matrix_scan_top #(
  parameter int PANEL_WIDTH  = 64,
  parameter int PANEL_HEIGHT = 32,
  parameter int SCAN_ROWS    = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                opcode,
  input  logic [dclms_pkg::PIXEL_X_W-1:0]     pixel_x,
  input  logic [dclms_pkg::PIXEL_Y_W-1:0]     pixel_y,
  input  dclms_pkg::color_t                   pixel_color,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                red_upper_n,
  output logic                                red_lower_n,
  output logic                                green_upper_n,
  output logic                                green_lower_n,
  output logic [dclms_pkg::ROW_ADDR_W-1:0]    row_address,
  output logic                                latch_last
);

  localparam int AW   = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
  localparam int CW   = $clog2(PANEL_WIDTH);
  localparam int SRW  = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;
  localparam int SUMW = 7;
  localparam int DW   = 2 * PANEL_WIDTH;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DRAW  = 2'd1;
  localparam logic [1:0] S_LOAD  = 2'd2;
  localparam logic [1:0] S_SHIFT = 2'd3;

  logic [1:0]              state;
  logic [1:0]              state_next;
  logic [SRW-1:0]          scan_row;
  logic [CW-1:0]           col;
  logic [PANEL_HEIGHT-1:0] row_valid;

  // frame store: word is {green row, red row}
  logic [DW-1:0]           mem [PANEL_HEIGHT];
  logic [DW-1:0]           rd_a;
  logic [DW-1:0]           rd_b;
  logic [DW-1:0]           wr_word;
  logic [PANEL_WIDTH-1:0]  wr_red;
  logic [PANEL_WIDTH-1:0]  wr_green;

  logic [AW-1:0]           draw_y;
  logic [CW-1:0]           draw_x;
  dclms_pkg::color_t       draw_color;
  logic                    draw_row_ok;
  logic                    up_ok;
  logic                    lo_ok;

  logic [PANEL_WIDTH-1:0]  sh_ru;
  logic [PANEL_WIDTH-1:0]  sh_rl;
  logic [PANEL_WIDTH-1:0]  sh_gu;
  logic [PANEL_WIDTH-1:0]  sh_gl;

  logic                    in_acc;
  logic                    out_acc;
  logic                    draw_in_range;
  logic [SUMW-1:0]         upper_sum;
  logic [SUMW-1:0]         lower_sum;
  logic                    upper_in;
  logic                    lower_in;
  logic [AW-1:0]           upper_idx;
  logic [AW-1:0]           lower_idx;
  logic [AW-1:0]           rd_addr_a;
  logic                    col_last;

  // handshake
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_SHIFT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign col_last  = (col == CW'(PANEL_WIDTH - 1));

  // bounds and row addresses
  assign draw_in_range = ({1'b0, pixel_x} < (dclms_pkg::PIXEL_X_W + 1)'(PANEL_WIDTH)) &&
                         ({1'b0, pixel_y} < (dclms_pkg::PIXEL_Y_W + 1)'(PANEL_HEIGHT));
  assign upper_sum = SUMW'(scan_row);
  assign lower_sum = SUMW'(scan_row) + SUMW'(SCAN_ROWS);
  assign upper_in  = (upper_sum < SUMW'(PANEL_HEIGHT));
  assign lower_in  = (lower_sum < SUMW'(PANEL_HEIGHT));
  assign upper_idx = upper_sum[AW-1:0];
  assign lower_idx = lower_sum[AW-1:0];
  assign rd_addr_a = (opcode == dclms_pkg::OP_DRAW) ? pixel_y[AW-1:0] : upper_idx;

  // read-modify-write word for a draw
  always_comb begin
    wr_red   = draw_row_ok ? rd_a[PANEL_WIDTH-1:0] : '0;
    wr_green = draw_row_ok ? rd_a[DW-1:PANEL_WIDTH] : '0;
    wr_red[draw_x]   = draw_color[dclms_pkg::COLOR_RED_BIT];
    wr_green[draw_x] = draw_color[dclms_pkg::COLOR_GREEN_BIT];
  end

  assign wr_word = {wr_green, wr_red};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (opcode == dclms_pkg::OP_TICK) begin
            state_next = S_LOAD;
          end else if (draw_in_range) begin
            state_next = S_DRAW;
          end
        end
      end
      S_DRAW:  state_next = S_IDLE;
      S_LOAD:  state_next = S_SHIFT;
      S_SHIFT: begin
        if (out_acc && col_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_row  <= '0;
      col       <= '0;
      row_valid <= '0;
    end else begin
      state <= state_next;
      if (state == S_DRAW) begin
        row_valid[draw_y] <= 1'b1;
      end
      if (state == S_LOAD) begin
        col <= '0;
      end else if (out_acc) begin
        col <= col + 1'b1;
        if (col_last) begin
          scan_row <= (scan_row == SRW'(SCAN_ROWS - 1)) ? '0 : scan_row + 1'b1;
        end
      end
    end
  end

  // frame store ports
  always_ff @(posedge clk) begin
    if (state == S_DRAW) begin
      mem[draw_y] <= wr_word;
    end
    if (in_acc) begin
      rd_a <= mem[rd_addr_a];
      rd_b <= mem[lower_idx];
    end
  end

  // transaction capture and column shift registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      draw_x      <= pixel_x[CW-1:0];
      draw_y      <= pixel_y[AW-1:0];
      draw_color  <= pixel_color;
      draw_row_ok <= row_valid[pixel_y[AW-1:0]];
      up_ok       <= upper_in && row_valid[upper_idx];
      lo_ok       <= lower_in && row_valid[lower_idx];
    end
    if (state == S_LOAD) begin
      sh_ru <= up_ok ? rd_a[PANEL_WIDTH-1:0] : '0;
      sh_gu <= up_ok ? rd_a[DW-1:PANEL_WIDTH] : '0;
      sh_rl <= lo_ok ? rd_b[PANEL_WIDTH-1:0] : '0;
      sh_gl <= lo_ok ? rd_b[DW-1:PANEL_WIDTH] : '0;
    end else if (out_acc) begin
      sh_ru <= {1'b0, sh_ru[PANEL_WIDTH-1:1]};
      sh_gu <= {1'b0, sh_gu[PANEL_WIDTH-1:1]};
      sh_rl <= {1'b0, sh_rl[PANEL_WIDTH-1:1]};
      sh_gl <= {1'b0, sh_gl[PANEL_WIDTH-1:1]};
    end
  end

  // result payload
  assign red_upper_n   = ~sh_ru[0];
  assign red_lower_n   = ~sh_rl[0];
  assign green_upper_n = ~sh_gu[0];
  assign green_lower_n = ~sh_gl[0];
  assign latch_last    = col_last;
  assign row_address   = col_last ? dclms_pkg::ROW_ADDR_W'(scan_row) : '0;

`ifndef SYNTH
  // no new transaction is taken while a row is being shifted out
  a_busy_while_shift: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted during row shift");

  // a taken tick passes through the load state before shifting starts
  a_tick_to_shift: assert property (@(posedge clk) disable iff (rst)
    (in_acc && opcode == dclms_pkg::OP_TICK) |=> ##1 out_valid)
    else $error("tick did not start shift");

  // the latch column ends the row
  a_latch_ends_row: assert property (@(posedge clk) disable iff (rst)
    (out_acc && latch_last) |=> !out_valid)
    else $error("shift continued past latch column");

  // scan row advances only with the latch transaction
  a_scan_row_hold: assert property (@(posedge clk) disable iff (rst)
    !(out_acc && latch_last) |=> $stable(scan_row))
    else $error("scan row changed outside latch");
`endif

endmodule

### tb/dual_color_led_matrix_scan_top_tb.sv
`timescale 1ns / 1ps

module dual_color_led_matrix_scan_top_tb;

  localparam int PANEL_WIDTH    = 64;
  localparam int PANEL_HEIGHT   = 32;
  localparam int SCAN_ROWS      = 16;
  localparam int RANDOM_ITEMS   = 350;
  localparam int MAX_GAP        = 12;
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam int PIXEL_X_W  = dclms_pkg::PIXEL_X_W;
  localparam int PIXEL_Y_W  = dclms_pkg::PIXEL_Y_W;
  localparam int ROW_ADDR_W = dclms_pkg::ROW_ADDR_W;

  localparam dclms_pkg::color_t CLR_OFF    = 2'd0;
  localparam dclms_pkg::color_t CLR_RED    = 2'd1;
  localparam dclms_pkg::color_t CLR_GREEN  = 2'd2;
  localparam dclms_pkg::color_t CLR_YELLOW = 2'd3;

  typedef struct packed {
    logic                  red_upper_n;
    logic                  red_lower_n;
    logic                  green_upper_n;
    logic                  green_lower_n;
    logic [ROW_ADDR_W-1:0] row_address;
    logic                  latch_last;
  } scan_column_t;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic                  opcode      = dclms_pkg::OP_DRAW;
  logic [PIXEL_X_W-1:0]  pixel_x     = '0;
  logic [PIXEL_Y_W-1:0]  pixel_y     = '0;
  dclms_pkg::color_t     pixel_color = CLR_OFF;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic                  red_upper_n;
  logic                  red_lower_n;
  logic                  green_upper_n;
  logic                  green_lower_n;
  logic [ROW_ADDR_W-1:0] row_address;
  logic                  latch_last;

  // frame image and scan position as the block should hold them
  logic [PANEL_WIDTH-1:0] red_frame   [PANEL_HEIGHT];
  logic [PANEL_WIDTH-1:0] green_frame [PANEL_HEIGHT];
  int unsigned            model_scan_row;
  scan_column_t           expected_columns [$];

  bit burst_mode  = 1'b0;
  int error_count = 0;
  int sink_hold   = 0;
  int idle_cycles = 0;

  dual_color_led_matrix_scan_top #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT),
    .SCAN_ROWS   (SCAN_ROWS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_color  (pixel_color),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red_upper_n  (red_upper_n),
    .red_lower_n  (red_lower_n),
    .green_upper_n(green_upper_n),
    .green_lower_n(green_lower_n),
    .row_address  (row_address),
    .latch_last   (latch_last)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // update the frame image on a draw, or expand a tick into its shifted columns
  task automatic model_transaction(logic op, logic [PIXEL_X_W-1:0] x,
                                   logic [PIXEL_Y_W-1:0] y, dclms_pkg::color_t c);
    scan_column_t col_exp;
    int unsigned  lower;
    if (op == dclms_pkg::OP_DRAW) begin
      // pixels off the panel leave the image alone
      if (x < PANEL_WIDTH && y < PANEL_HEIGHT) begin
        red_frame[y][x]   = c[dclms_pkg::COLOR_RED_BIT];
        green_frame[y][x] = c[dclms_pkg::COLOR_GREEN_BIT];
      end
    end else begin
      lower = model_scan_row + SCAN_ROWS;
      for (int col = 0; col < PANEL_WIDTH; col++) begin
        col_exp.red_upper_n   = ~red_frame[model_scan_row][col];
        col_exp.green_upper_n = ~green_frame[model_scan_row][col];
        col_exp.red_lower_n   = (lower < PANEL_HEIGHT) ? ~red_frame[lower][col] : 1'b1;
        col_exp.green_lower_n = (lower < PANEL_HEIGHT) ? ~green_frame[lower][col] : 1'b1;
        col_exp.latch_last    = (col == PANEL_WIDTH - 1);
        col_exp.row_address   = col_exp.latch_last ? ROW_ADDR_W'(model_scan_row) : '0;
        expected_columns.push_back(col_exp);
      end
      model_scan_row = (model_scan_row + 1) % SCAN_ROWS;
    end
  endtask

  // drive one input transaction after a random gap (none in burst mode) and wait for its acceptance
  task automatic send_item(logic op, logic [PIXEL_X_W-1:0] x,
                           logic [PIXEL_Y_W-1:0] y, dclms_pkg::color_t c);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(MAX_GAP, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    pixel_x     <= x;
    pixel_y     <= y;
    pixel_color <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_transaction(op, x, y, c);
  endtask

  // hold off the sender until every shifted column has come out
  task automatic wait_for_scan_drain();
    in_valid <= 1'b0;
    while (expected_columns.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic compare_field(string field, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      error_count++;
    end
  endtask

  // corners of both halves, overwrite with off, then scan row 0
  task automatic test_draw_extremes();
    send_item(dclms_pkg::OP_DRAW, 7'd0, 6'd0, CLR_RED);
    send_item(dclms_pkg::OP_DRAW, 7'd63, 6'd0, CLR_GREEN);
    send_item(dclms_pkg::OP_DRAW, 7'd63, 6'd16, CLR_YELLOW);
    send_item(dclms_pkg::OP_DRAW, 7'd0, 6'd16, CLR_YELLOW);
    send_item(dclms_pkg::OP_DRAW, 7'd31, 6'd0, CLR_YELLOW);
    send_item(dclms_pkg::OP_DRAW, 7'd31, 6'd0, CLR_OFF);
    send_item(dclms_pkg::OP_DRAW, 7'd32, 6'd16, CLR_GREEN);
    send_item(dclms_pkg::OP_TICK, 7'd0, 6'd0, CLR_OFF);
  endtask

  // off-panel draws that would alias onto row 1, 17 or 31 if wrapped, tick with full operands
  task automatic test_outside_panel();
    send_item(dclms_pkg::OP_DRAW, 7'd64, 6'd1, CLR_YELLOW);
    send_item(dclms_pkg::OP_DRAW, 7'd127, 6'd1, CLR_YELLOW);
    send_item(dclms_pkg::OP_DRAW, 7'd0, 6'd33, CLR_YELLOW);
    send_item(dclms_pkg::OP_DRAW, 7'd5, 6'd49, CLR_YELLOW);
    send_item(dclms_pkg::OP_DRAW, 7'd127, 6'd63, CLR_YELLOW);
    send_item(dclms_pkg::OP_DRAW, 7'd10, 6'd1, CLR_RED);
    send_item(dclms_pkg::OP_TICK, 7'd127, 6'd63, CLR_YELLOW);
  endtask

  // no idling on either side
  task automatic test_back_to_back();
    burst_mode = 1'b1;
    send_item(dclms_pkg::OP_DRAW, 7'd2, 6'd2, CLR_GREEN);
    send_item(dclms_pkg::OP_DRAW, 7'd3, 6'd18, CLR_RED);
    send_item(dclms_pkg::OP_TICK, 7'd85, 6'd42, CLR_RED);
    send_item(dclms_pkg::OP_TICK, 7'd42, 6'd21, CLR_GREEN);
    burst_mode = 1'b0;
    wait_for_scan_drain();
  endtask

  // mostly on-panel draws and ticks, some draws over the whole field range
  task automatic test_random_traffic();
    int kind;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) wait_for_scan_drain();
      burst_mode = (i >= RANDOM_ITEMS / 2) && (i < RANDOM_ITEMS / 2 + 60);
      kind = $urandom_range(99, 0);
      if (kind < 28)
        send_item(dclms_pkg::OP_TICK, PIXEL_X_W'($urandom), PIXEL_Y_W'($urandom),
                  dclms_pkg::color_t'($urandom));
      else if (kind < 88)
        send_item(dclms_pkg::OP_DRAW, PIXEL_X_W'($urandom_range(PANEL_WIDTH - 1, 0)),
                  PIXEL_Y_W'($urandom_range(PANEL_HEIGHT - 1, 0)),
                  dclms_pkg::color_t'($urandom));
      else
        send_item(dclms_pkg::OP_DRAW, PIXEL_X_W'($urandom), PIXEL_Y_W'($urandom),
                  dclms_pkg::color_t'($urandom));
    end
    burst_mode = 1'b0;
  endtask

  // result side: random stall per column (none in burst mode), compare against the oldest expectation
  always @(posedge clk) begin : column_check
    scan_column_t got;
    scan_column_t want;
    if (rst) begin
      out_stall <= 1'b0;
      sink_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {red_upper_n, red_lower_n, green_upper_n, green_lower_n, row_address,
               latch_last};
        if (expected_columns.size() == 0) begin
          $display("%0t ns: unexpected column, expected none, actual %h", $time, got);
          error_count++;
        end else begin
          want = expected_columns.pop_front();
          compare_field("red_upper_n", want.red_upper_n, got.red_upper_n);
          compare_field("red_lower_n", want.red_lower_n, got.red_lower_n);
          compare_field("green_upper_n", want.green_upper_n, got.green_upper_n);
          compare_field("green_lower_n", want.green_lower_n, got.green_lower_n);
          compare_field("row_address", want.row_address, got.row_address);
          compare_field("latch_last", want.latch_last, got.latch_last);
        end
        sink_hold = burst_mode ? 0 : $urandom_range(MAX_GAP, 0);
      end else if (sink_hold > 0) begin
        sink_hold--;
      end
      out_stall <= (sink_hold != 0);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int r = 0; r < PANEL_HEIGHT; r++) begin
      red_frame[r]   = '0;
      green_frame[r] = '0;
    end
    model_scan_row = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_draw_extremes();
    test_outside_panel();
    test_back_to_back();
    test_random_traffic();
    wait_for_scan_drain();
    if (error_count == 0 && expected_columns.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### dual_color_led_matrix_scan_top.f
rtl/core/dclms_pkg.sv
rtl/core/dual_color_led_matrix_scan_top.sv
tb/dual_color_led_matrix_scan_top_tb.sv
